[hw/rtl/stm_pkg.sv]
// stm_pkg: shared types, constants and the sine table for the sine tremolo modulator
// used by stm_mul, stm_seq, sine_tremolo_modulator and its checker

package stm_pkg;

  // widths of the datapath
  localparam int PHASE_BITS   = 16;
  localparam int TABLE_BITS   = 8;
  localparam int SAMPLE_BITS  = 12;
  localparam int QUARTER_BITS = TABLE_BITS - 2;
  localparam int TABLE_DEPTH  = 1 << TABLE_BITS;

  // fixed port widths
  localparam int IN_W   = 12;
  localparam int OUT_W  = 12;
  localparam int CFG_W  = 16;
  localparam int CIDX_W = 2;

  // sine values are signed Q1.15 in -32768..32768
  localparam int SINE_W = 17;
  // multiplier operands and product
  localparam int MOP_W  = 17;
  localparam int PROD_W = 2 * MOP_W;
  localparam int ENV_W  = 16;
  // envelope numerator, signed
  localparam int NUM_W  = 35;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

  // register reset values
  localparam logic [CFG_W-1:0] PHASE_STEP_RST   = 16'd0;
  localparam logic [CFG_W-1:0] GAIN_FLOOR_RST   = 16'd3277;
  localparam logic [CFG_W-1:0] GAIN_CEILING_RST = 16'd32768;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_PHASE_STEP   = 2'd0,
    CFG_GAIN_FLOOR   = 2'd1,
    CFG_GAIN_CEILING = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL_ENV,
    ST_ENV,
    ST_MUL_OUT,
    ST_SAT
  } state_t;

  // multiplier operand select
  typedef enum logic {
    MSEL_ENV,
    MSEL_OUT
  } msel_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic  look_en;
    logic  mul_en;
    msel_t mul_sel;
    logic  env_en;
    logic  out_load;
  } ctrl_t;

  typedef logic signed [SINE_W-1:0] sine_tab_t [TABLE_DEPTH];

  // polynomial constants, Q28
  localparam longint unsigned POLY_A = 64'd421657428;
  localparam longint unsigned POLY_B = 64'd173399669;
  localparam longint unsigned POLY_C = 64'd21392319;
  localparam longint unsigned POLY_D = 64'd1214622;

  // full-wave sine table built from the quarter-wave polynomial
  function automatic sine_tab_t build_sine_table();
    sine_tab_t       tab;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned x;
    longint unsigned u;
    longint unsigned t;
    longint unsigned q;
    longint          sv;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      quad = (longint'(i) >> QUARTER_BITS) & 64'd3;
      r    = longint'(i) & ((64'd1 << QUARTER_BITS) - 64'd1);
      x    = r << (15 - QUARTER_BITS);
      if (quad[0]) x = 64'd32768 - x;
      u    = (x * x) >> 15;
      t    = POLY_D;
      t    = POLY_C - ((t * u) >> 15);
      t    = POLY_B - ((t * u) >> 15);
      t    = POLY_A - ((t * u) >> 15);
      q    = (t * x) >> 28;
      sv   = quad[1] ? -longint'(q) : longint'(q);
      tab[i] = SINE_W'(sv);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

[hw/rtl/stm_mul.sv]
// stm_mul: shared signed multiplier with registered product
// depends on stm_pkg for operand and product widths

module stm_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [stm_pkg::MOP_W-1:0]     a,
  input  logic signed [stm_pkg::MOP_W-1:0]     b,
  output logic signed [stm_pkg::PROD_W-1:0]    prod
);

  // one multiply per enabled cycle
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

[hw/rtl/stm_seq.sv]
// stm_seq: sequencer that steps one word through lookup, envelope and scaling
// depends on stm_pkg for state_t and ctrl_t

module stm_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           out_free,
  output logic           idle,
  output stm_pkg::ctrl_t ctrl
);

  stm_pkg::state_t state;
  stm_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next    = state;
    ctrl          = '0;
    ctrl.mul_sel  = stm_pkg::MSEL_ENV;
    idle          = 1'b0;
    unique case (state)
      stm_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (start) state_next = stm_pkg::ST_LOOK;
      end
      stm_pkg::ST_LOOK: begin
        ctrl.look_en = 1'b1;
        state_next   = stm_pkg::ST_MUL_ENV;
      end
      stm_pkg::ST_MUL_ENV: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = stm_pkg::MSEL_ENV;
        state_next   = stm_pkg::ST_ENV;
      end
      stm_pkg::ST_ENV: begin
        ctrl.env_en = 1'b1;
        state_next  = stm_pkg::ST_MUL_OUT;
      end
      stm_pkg::ST_MUL_OUT: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = stm_pkg::MSEL_OUT;
        state_next   = stm_pkg::ST_SAT;
      end
      stm_pkg::ST_SAT: begin
        // wait here while the previous word is still unread
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = stm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/sine_tremolo_modulator.sv]
// sine_tremolo_modulator: phase accumulator, sine table and shared-multiplier envelope scaling
// each word passes the lookup, envelope multiply, envelope, output multiply and saturate
// states, the last of which waits until the output is free; a new word is taken only when
// idle, after both multiplies through the single 17x17 multiplier and the envelope add
// reset: phase accumulator to zero, registers to defaults, no output pending
// depends on stm_pkg, stm_seq and stm_mul

module sine_tremolo_modulator (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [stm_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [stm_pkg::CFG_W-1:0]    cfg_data,
  // input words
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [stm_pkg::IN_W-1:0]     sample_in,
  // output words
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [stm_pkg::OUT_W-1:0]    sample_out
);

  logic [stm_pkg::CFG_W-1:0]            phase_step;
  logic [stm_pkg::CFG_W-1:0]            gain_floor;
  logic [stm_pkg::CFG_W-1:0]            gain_ceiling;
  logic [stm_pkg::PHASE_BITS-1:0]       phase_acc;
  logic [stm_pkg::SAMPLE_BITS-1:0]      sample;
  logic signed [stm_pkg::SINE_W-1:0]    sine;
  logic [stm_pkg::ENV_W-1:0]            env;
  logic [stm_pkg::TABLE_BITS-1:0]       tab_idx;
  logic signed [stm_pkg::MOP_W-1:0]     mul_a;
  logic signed [stm_pkg::MOP_W-1:0]     mul_b;
  logic signed [stm_pkg::PROD_W-1:0]    prod;
  logic signed [stm_pkg::NUM_W-1:0]     num;
  logic [stm_pkg::PROD_W-16:0]          scaled;
  logic [stm_pkg::SAMPLE_BITS-1:0]      sat;
  logic                                 in_acc;
  logic                                 out_free;
  logic                                 idle;
  stm_pkg::ctrl_t                       ctrl;

  assign cfg_ready = 1'b1;
  assign in_ready  = idle;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= stm_pkg::PHASE_STEP_RST;
      gain_floor   <= stm_pkg::GAIN_FLOOR_RST;
      gain_ceiling <= stm_pkg::GAIN_CEILING_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (stm_pkg::cfg_idx_t'(cfg_index))
        stm_pkg::CFG_PHASE_STEP:   phase_step   <= cfg_data;
        stm_pkg::CFG_GAIN_FLOOR:   gain_floor   <= cfg_data;
        stm_pkg::CFG_GAIN_CEILING: gain_ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  // phase advance and sample capture on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (in_acc) begin
      phase_acc <= phase_acc + stm_pkg::PHASE_BITS'(phase_step);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample <= stm_pkg::SAMPLE_BITS'(sample_in);
    end
  end

  // table index from the top phase bits
  if (stm_pkg::PHASE_BITS >= stm_pkg::TABLE_BITS) begin : g_idx_shr
    assign tab_idx = phase_acc[stm_pkg::PHASE_BITS-1 -: stm_pkg::TABLE_BITS];
  end else begin : g_idx_shl
    assign tab_idx = {phase_acc, {(stm_pkg::TABLE_BITS - stm_pkg::PHASE_BITS){1'b0}}};
  end

  // sine lookup
  always_ff @(posedge clk) begin
    if (ctrl.look_en) begin
      sine <= stm_pkg::SINE_TABLE[tab_idx];
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (ctrl.mul_sel)
      stm_pkg::MSEL_ENV: begin
        mul_a = $signed({1'b0, gain_ceiling}) - $signed({1'b0, gain_floor});
        mul_b = sine;
      end
      default: begin
        mul_a = $signed({1'b0, env});
        mul_b = $signed(stm_pkg::MOP_W'(sample));
      end
    endcase
  end

  stm_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // envelope: midpoint plus half-span times sine, clamped at zero
  assign num = $signed({2'b00, ({1'b0, gain_floor} + {1'b0, gain_ceiling}), 15'd0})
             + stm_pkg::NUM_W'(prod);

  always_ff @(posedge clk) begin
    if (ctrl.env_en) begin
      env <= num[stm_pkg::NUM_W-1] ? '0 : num[31:16];
    end
  end

  // scale down and saturate
  assign scaled = prod[stm_pkg::PROD_W-1:15];
  assign sat    = (scaled > (stm_pkg::PROD_W - 15)'(stm_pkg::SAMPLE_MAX))
                ? stm_pkg::SAMPLE_MAX : scaled[stm_pkg::SAMPLE_BITS-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      sample_out <= stm_pkg::OUT_W'(sat);
    end
  end

  stm_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc),
    .out_free (out_free),
    .idle     (idle),
    .ctrl     (ctrl)
  );

endmodule

[hw/rtl/stm_checker.sv]
// stm_checker: port-level assertions for the sine tremolo modulator
// depends on stm_pkg; bound to sine_tremolo_modulator below

module stm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [stm_pkg::OUT_W-1:0]   sample_out
);

  // busy for the whole sequence after an accepted word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready
      ##1 !in_ready)
    else $error("input accepted while a word is in progress");

  // a rising out_valid must follow an accepted input word
  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 6))
    else $error("result appeared without a matching input word");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
    else $error("stalled output word changed or dropped");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind sine_tremolo_modulator stm_checker u_stm_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out)
);

[tb/tb_sine_tremolo_modulator.sv]
// tb_sine_tremolo_modulator: self-checking bench for the sine tremolo modulator, with an
// envelope tracker that predicts each output word, plus random idling and back-pressure
// depends on stm_pkg and sine_tremolo_modulator
`timescale 1ns / 100ps

module tb_sine_tremolo_modulator;

  // quarter-wave polynomial coefficients, Q28
  localparam longint unsigned SINE_K3 = 64'd421657428;
  localparam longint unsigned SINE_K2 = 64'd173399669;
  localparam longint unsigned SINE_K1 = 64'd21392319;
  localparam longint unsigned SINE_K0 = 64'd1214622;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 80;

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [stm_pkg::CIDX_W-1:0] cfg_index;
  logic [stm_pkg::CFG_W-1:0]  cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [stm_pkg::IN_W-1:0]   sample_in;
  logic                       out_valid;
  logic                       out_ready;
  logic [stm_pkg::OUT_W-1:0]  sample_out;

  // traffic shaping shared by the driver processes
  bit tx_idle;
  bit rx_idle;
  bit hold_off_req;
  int settings_used;

  // tracks phase and gains, predicts the modulated word for each accepted sample
  class tremolo_tracker;
    logic [15:0] phase_acc;
    logic [15:0] phase_step;
    logic [15:0] gain_floor;
    logic [15:0] gain_ceiling;
    logic [11:0] modulated_q[$];
    int          mismatches;
    int          checked;

    function new();
      phase_acc    = 16'd0;
      phase_step   = 16'd0;
      gain_floor   = 16'd3277;
      gain_ceiling = 16'd32768;
      mismatches   = 0;
      checked      = 0;
    endfunction

    function void set_register(stm_pkg::cfg_idx_t idx, logic [15:0] value);
      case (idx)
        stm_pkg::CFG_PHASE_STEP:   phase_step   = value;
        stm_pkg::CFG_GAIN_FLOOR:   gain_floor   = value;
        stm_pkg::CFG_GAIN_CEILING: gain_ceiling = value;
        default: ;
      endcase
    endfunction

    // first quarter of sine, Q15 in and out
    function longint quarter_wave(longint unsigned frac);
      longint unsigned sq;
      longint unsigned acc;
      sq  = (frac * frac) >> 15;
      acc = SINE_K0;
      acc = SINE_K1 - ((acc * sq) >> 15);
      acc = SINE_K2 - ((acc * sq) >> 15);
      acc = SINE_K3 - ((acc * sq) >> 15);
      return longint'((acc * frac) >> 28);
    endfunction

    // signed Q1.15 sine for a table index, folded from the quarter wave
    function longint table_sine(logic [7:0] idx);
      logic [1:0]      quad;
      longint unsigned frac;
      longint          q;
      quad = idx[7:6];
      frac = {58'd0, idx[5:0]} << 9;
      if (quad[0]) frac = 64'd32768 - frac;
      q = quarter_wave(frac);
      return quad[1] ? -q : q;
    endfunction

    // advance the phase, form the envelope and scale the word
    function logic [11:0] modulate(logic [11:0] value);
      longint          sine;
      longint          num;
      longint unsigned env;
      longint unsigned prod;
      phase_acc = phase_acc + phase_step;
      sine = table_sine(phase_acc[15:8]);
      num  = (longint'(gain_floor) + longint'(gain_ceiling)) * 32768
           + (longint'(gain_ceiling) - longint'(gain_floor)) * sine;
      if (num < 0) num = 0;
      env  = longint'(num) >> 16;
      prod = ({52'd0, value} * env) >> 15;
      if (prod > 64'd4095) prod = 64'd4095;
      return prod[11:0];
    endfunction

    function void note_sample(logic [11:0] value);
      modulated_q.push_back(modulate(value));
    endfunction

    function int pending();
      return modulated_q.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_sample(logic [11:0] got);
      logic [11:0] want;
      if (modulated_q.size() == 0) begin
        report_mismatch($sformatf("sample_out %0d with no word expected", got));
      end else begin
        want = modulated_q.pop_front();
        checked++;
        if (got !== want)
          report_mismatch($sformatf("word %0d: sample_out %0d, expected %0d",
                                    checked, got, want));
      end
    endtask
  endclass

  tremolo_tracker tracker;

  sine_tremolo_modulator i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [11:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 12'd0;
    if (r == 1) return 12'd4095;
    return 12'($urandom);
  endfunction

  function automatic logic [15:0] pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'd32768;
    if (r == 2) return 16'd65535;
    if (r == 3) return 16'($urandom);
    return 16'($urandom_range(0, 32768));
  endfunction

  function automatic logic [15:0] pick_step();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'd65535;
    if (r == 2) return 16'd1;
    if (r == 3) return 16'd32768;
    return 16'($urandom);
  endfunction

  // offer one word; valid stays up after acceptance until the next call decides
  task automatic send_word(input logic [11:0] value);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_in = value;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every expected word is back
  task automatic finish_burst();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
  endtask

  task automatic write_reg(input stm_pkg::cfg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] step, input logic [15:0] lo,
                               input logic [15:0] hi);
    write_reg(stm_pkg::CFG_PHASE_STEP, step);
    write_reg(stm_pkg::CFG_GAIN_FLOOR, lo);
    write_reg(stm_pkg::CFG_GAIN_CEILING, hi);
    settings_used++;
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        stall = rx_idle ? pick_gap() : 0;
        if (stall > 0) begin
          out_ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready = 1'b1;
      end
    end
  end

  // handshake monitor: results checked first, then new words and register writes
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) tracker.check_sample(sample_out);
      if (in_valid && in_ready) tracker.note_sample(sample_in);
      if (cfg_valid && cfg_ready)
        tracker.set_register(stm_pkg::cfg_idx_t'(cfg_index), cfg_data);
    end
  end

  // stop a hung run when no handshake happens for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
             WATCHDOG_LIMIT, tracker.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [11:0] edge_words [6];
    tracker       = new();
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = stm_pkg::CFG_PHASE_STEP;
    cfg_data      = '0;
    in_valid      = 1'b0;
    sample_in     = '0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    hold_off_req  = 1'b0;
    settings_used = 1;
    edge_words    = '{12'd0, 12'd4095, 12'd1, 12'd2048, 12'hAAA, 12'h555};
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // reset settings: phase stays at zero, envelope sits at the gain midpoint
    foreach (edge_words[i]) send_word(edge_words[i]);
    finish_burst();

    // quarter-turn step visits all four quadrants at full-depth swing
    load_settings(16'd16384, 16'd0, 16'd32768);
    repeat (4) send_word(12'd4095);
    repeat (4) send_word(12'd2048);
    finish_burst();

    // gains above unity saturate the output, full-range step wraps the phase
    load_settings(16'd65535, 16'd65535, 16'd65535);
    send_word(12'd4095);
    send_word(12'd1);
    send_word(12'd2048);
    send_word(12'd2);
    finish_burst();

    // floor above ceiling swings in inverted phase
    load_settings(16'd8192, 16'd32768, 16'd0);
    repeat (4) send_word(12'd4095);
    finish_burst();

    // write to the unused index is ignored; zero gains silence the output
    write_reg(stm_pkg::CFG_UNUSED, 16'hFFFF);
    load_settings(16'd12345, 16'd0, 16'd0);
    repeat (3) send_word(12'd4095);

    // random phases, each with fresh settings and its own idling mix
    for (int ph = 0; ph < 8; ph++) begin
      finish_burst();
      if ($urandom_range(0, 3) == 0) write_reg(stm_pkg::CFG_UNUSED, 16'($urandom));
      load_settings(pick_step(), pick_gain(), pick_gain());
      tx_idle = (ph % 4) != 1;
      rx_idle = (ph % 4) != 2;
      for (int n = 0; n < 80; n++) begin
        // long output hold-off while words keep coming back to back
        if (ph == 3 && n == 20) begin
          hold_off_req = 1'b1;
          tx_idle      = 1'b0;
        end
        if (ph == 3 && n == 45) tx_idle = 1'b1;
        // sender pauses until the pipeline has fully drained
        if (ph == 5 && n == 40) finish_burst();
        send_word(pick_word());
      end
    end

    finish_burst();
    repeat (10) @(negedge clk);
    $display("run summary: %0d words checked over %0d gain/step settings,",
             tracker.checked, settings_used);
    $display("incl. saturation, inverted and zero gains, phase wrap and a full output stall");
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
